// File: rtl/vgd_pkg.sv
// Package for the voxel grid downsampler: field widths, table geometry,
// hash constants and the hash helper. No dependencies.
package vgd_pkg;

  // Point and register fields
  localparam int COORD_W     = 21;
  localparam int INV_W       = 17;
  localparam logic [INV_W-1:0] INV_RESET = INV_W'(655);
  localparam int PROD_W      = COORD_W + INV_W + 1;
  localparam int FRAC_W      = 16;

  // Voxel key: three 18-bit wrapped indices, x in the lowest bits
  localparam int KEY_FIELD_W = 18;
  localparam int KEY_W       = 3 * KEY_FIELD_W;

  // Hash table geometry (depth is a power of two)
  localparam int TABLE_DEPTH = 4096;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);

  // Table entry: frame epoch above the key; epoch zero never matches
  localparam int EPOCH_W     = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_MAX   = {EPOCH_W{1'b1}};
  localparam int ENTRY_W     = EPOCH_W + KEY_W;

  // Spatial hash
  localparam int HASH_W = 20;
  localparam logic [31:0] HASH_PX = 32'd73856093;
  localparam logic [31:0] HASH_PY = 32'd19349663;
  localparam logic [31:0] HASH_PZ = 32'd83492791;

  // Controller states
  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_KEY   = 6'b001000,
    ST_HASH  = 6'b010000,
    ST_PROBE = 6'b100000
  } state_t;

  // Low hash bits of a sign-extended key field times a hash prime
  function automatic logic [HASH_W-1:0] hash_term(input logic [KEY_FIELD_W-1:0] k,
                                                  input logic [31:0] c);
    logic [HASH_W-1:0]   kw;
    logic [2*HASH_W-1:0] prod;
    kw   = {{(HASH_W-KEY_FIELD_W){k[KEY_FIELD_W-1]}}, k};
    prod = kw * c[HASH_W-1:0];
    return prod[HASH_W-1:0];
  endfunction

endpackage

// File: rtl/voxel_grid_downsample.sv
// Steps per point: capture, multiply, build key, hash, then one or more probes; result is registered.
// A new point is taken only in idle, after the last one is done (one table read per probe cycle).
// A full table probes every slot for that point.
// Reset: synchronous; a clearing pass over every table slot follows, input is held off meanwhile.
// A frame start clears by epoch; every 255th frame start runs the clearing pass again.
// Depends on vgd_pkg and vgd_ram.
module voxel_grid_downsample
  import vgd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Configuration: inv_voxel_size
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data,
  // Input points
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // point_x[20:0], point_y[41:21], point_z[62:42], pad
  input  logic        s_axis_tuser,  // frame_start
  // Kept points
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // kept_x[20:0], kept_y[41:21], kept_z[62:42], pad
  output logic        m_axis_tuser   // table_full
);

  state_t state, state_next;

  logic [INV_W-1:0]   inv_voxel_size;
  logic [EPOCH_W-1:0] epoch, epoch_next;
  logic [SLOT_W-1:0]  clr_addr;
  logic               clr_hold, clr_hold_next;

  logic signed [COORD_W-1:0] pt_x, pt_y, pt_z;
  logic signed [PROD_W-1:0]  prod_x, prod_y, prod_z;
  logic [KEY_FIELD_W-1:0]    key_x, key_y, key_z;
  logic [SLOT_W-1:0]         slot, slot_next;
  logic [SLOT_W-1:0]         probes, probes_next;

  logic               out_valid, out_valid_next;
  logic [COORD_W-1:0] out_x, out_y, out_z;
  logic               out_full;

  logic               in_fire;
  logic               out_free;
  logic               out_load, out_load_full;

  logic               ram_we;
  logic [SLOT_W-1:0]  ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic [HASH_W-1:0]  hash;
  logic [SLOT_W-1:0]  slot_hash, slot_inc;
  logic               slot_empty, slot_match, probes_done;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;

  // Table storage: epoch and voxel key per slot
  vgd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_voxel_size <= INV_RESET;
    end else if (cfg_valid && cfg_ready) begin
      inv_voxel_size <= cfg_data;
    end
  end

  // Hash of the registered voxel key, reduced to a slot
  assign hash = hash_term(key_x, HASH_PX) ^ hash_term(key_y, HASH_PY) ^
                hash_term(key_z, HASH_PZ);
  assign slot_hash = SLOT_W'(hash % TABLE_DEPTH);
  assign slot_inc  = (slot == SLOT_W'(TABLE_DEPTH - 1)) ? '0 : slot + SLOT_W'(1);

  // Probe decision on the entry read last cycle
  assign slot_empty  = (ram_rdata[ENTRY_W-1 -: EPOCH_W] != epoch);
  assign slot_match  = !slot_empty && (ram_rdata[KEY_W-1:0] == {key_z, key_y, key_x});
  assign probes_done = (probes == SLOT_W'(TABLE_DEPTH - 1));

  // Controller
  always_comb begin
    state_next    = state;
    epoch_next    = epoch;
    clr_hold_next = clr_hold;
    slot_next     = slot;
    probes_next   = probes;
    out_load      = 1'b0;
    out_load_full = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = slot;
    ram_wdata     = {epoch, key_z, key_y, key_x};
    ram_raddr     = slot;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (clr_addr == SLOT_W'(TABLE_DEPTH - 1)) begin
          state_next = clr_hold ? ST_MUL : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ST_MUL;
          if (s_axis_tuser) begin
            if (epoch == EPOCH_MAX) begin
              epoch_next    = EPOCH_FIRST;
              clr_hold_next = 1'b1;
              state_next    = ST_CLEAR;
            end else begin
              epoch_next = epoch + EPOCH_W'(1);
            end
          end
        end
      end
      ST_MUL: begin
        state_next = ST_KEY;
      end
      ST_KEY: begin
        state_next = ST_HASH;
      end
      ST_HASH: begin
        slot_next   = slot_hash;
        probes_next = '0;
        ram_raddr   = slot_hash;
        state_next  = ST_PROBE;
      end
      ST_PROBE: begin
        if (slot_empty) begin
          // New voxel: store it and emit the point
          if (out_free) begin
            ram_we     = 1'b1;
            out_load   = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (slot_match) begin
          // Known voxel: drop the point
          state_next = ST_IDLE;
        end else if (probes_done) begin
          // Every slot taken by another voxel
          if (out_free) begin
            out_load_full = 1'b1;
            state_next    = ST_IDLE;
          end
        end else begin
          slot_next   = slot_inc;
          probes_next = probes + SLOT_W'(1);
          ram_raddr   = slot_inc;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      epoch    <= EPOCH_FIRST;
      clr_hold <= 1'b0;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      epoch    <= epoch_next;
      clr_hold <= (state == ST_CLEAR && state_next != ST_CLEAR) ? 1'b0 : clr_hold_next;
      clr_addr <= (state == ST_CLEAR) ? clr_addr + SLOT_W'(1) : '0;
    end
  end

  // Datapath: capture, quantize, build key, walk the probe sequence
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pt_x <= s_axis_tdata[20:0];
      pt_y <= s_axis_tdata[41:21];
      pt_z <= s_axis_tdata[62:42];
    end
    if (state == ST_MUL) begin
      prod_x <= pt_x * $signed({1'b0, inv_voxel_size});
      prod_y <= pt_y * $signed({1'b0, inv_voxel_size});
      prod_z <= pt_z * $signed({1'b0, inv_voxel_size});
    end
    if (state == ST_KEY) begin
      // Truncate toward zero: bias negative products before the shift
      key_x <= 18'((prod_x + {{(PROD_W-FRAC_W){1'b0}}, {FRAC_W{prod_x[PROD_W-1]}}})
                   >>> FRAC_W);
      key_y <= 18'((prod_y + {{(PROD_W-FRAC_W){1'b0}}, {FRAC_W{prod_y[PROD_W-1]}}})
                   >>> FRAC_W);
      key_z <= 18'((prod_z + {{(PROD_W-FRAC_W){1'b0}}, {FRAC_W{prod_z[PROD_W-1]}}})
                   >>> FRAC_W);
    end
    slot   <= slot_next;
    probes <= probes_next;
  end

  // Output register: load a result, drop it once the transaction completes
  always_comb begin
    out_valid_next = out_valid;
    if (out_load || out_load_full) begin
      out_valid_next = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x    <= pt_x;
      out_y    <= pt_y;
      out_z    <= pt_z;
      out_full <= 1'b0;
    end else if (out_load_full) begin
      out_x    <= '0;
      out_y    <= '0;
      out_z    <= '0;
      out_full <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_z, out_y, out_x};
  assign m_axis_tuser  = out_full;

endmodule

// File: rtl/vgd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module vgd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
